// File: src/cpmt_pkg.sv
`default_nettype none
package cpmt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int SCAN_W   = IDX_W + 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CP_W     = 21;
  localparam int ENTRY_W  = 7;
  localparam int QDEPTH   = 2;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic            need_scan;
    logic [CP_W-1:0] key;
    logic [CP_W-1:0] val;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [CP_W-1:0]    value_out;
    logic               full_res;
    logic [ENTRY_W-1:0] entry_count;
  } res_t;

endpackage
`default_nettype wire

// File: src/cpmt_front.sv
`default_nettype none
module cpmt_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              in_cmd_i,
  input  wire logic [cpmt_pkg::CP_W-1:0] in_key_i,
  input  wire logic [cpmt_pkg::CP_W-1:0] in_val_i,
  output logic                         req_valid_o,
  input  wire logic                    req_ready_i,
  output cpmt_pkg::req_t               req_o
);
  import cpmt_pkg::*;

  req_t       q_mem [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  req_t       req_in;

  assign in_ready_o  = (cnt_q != 2'(QDEPTH));
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    req_in.cmd       = cmd_e'(in_cmd_i);
    req_in.need_scan = (cmd_e'(in_cmd_i) != CMD_CLEAR);
    req_in.key       = in_key_i;
    req_in.val       = in_val_i;
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: src/cpmt_back.sv
`default_nettype none
module cpmt_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire cpmt_pkg::req_t req_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output cpmt_pkg::res_t      res_o
);
  import cpmt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [CP_W-1:0] key_mem [CAPACITY];
  logic [CP_W-1:0] val_mem [CAPACITY];

  logic [1:0]          state_q, state_d;
  req_t                req_q;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SCAN_W-1:0]   issue_q, issue_d;
  logic                rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [CP_W-1:0]     key_rd_q, val_rd_q;
  logic                hit_q, hit_d, free_ok_q, free_ok_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [CP_W-1:0]     hit_val_q, hit_val_d;
  logic                out_vld_q, out_vld_d;
  res_t                res_q, res_d;
  logic                do_rd, do_fin, wr_key, wr_val;
  logic [IDX_W-1:0]    wr_idx;

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = out_vld_q;
  assign res_o       = res_q;
  assign do_rd  = (state_q == ST_SCAN) && (issue_q < SCAN_W'(CAPACITY));
  assign do_fin = (state_q == ST_FIN) && (!out_vld_q || res_ready_i);

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    count_d    = count_q;
    issue_d    = issue_q;
    rd_vld_d   = do_rd;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_val_d  = hit_val_q;
    free_ok_d  = free_ok_q;
    free_idx_d = free_idx_q;
    out_vld_d  = out_vld_q && !res_ready_i;
    res_d      = res_q;
    wr_key     = 1'b0;
    wr_val     = 1'b0;
    wr_idx     = hit_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          issue_d   = '0;
          hit_d     = 1'b0;
          free_ok_d = 1'b0;
          state_d   = req_i.need_scan ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (do_rd) begin
          issue_d = issue_q + SCAN_W'(1);
        end
        if (rd_vld_q) begin
          if (valid_q[rd_idx_q] && key_rd_q == req_q.key) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            hit_val_d = val_rd_q;
          end
          if (!valid_q[rd_idx_q] && !free_ok_q) begin
            free_ok_d  = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (rd_idx_q == IDX_W'(CAPACITY - 1)) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (do_fin) begin
          res_d.found     = hit_q && req_q.need_scan;
          res_d.value_out = '0;
          res_d.full_res  = 1'b0;
          case (req_q.cmd)
            CMD_CLEAR: begin
              valid_d = '0;
              count_d = '0;
            end
            CMD_ADD: begin
              if (hit_q) begin
                wr_val = 1'b1;
              end else if (free_ok_q) begin
                wr_key           = 1'b1;
                wr_val           = 1'b1;
                wr_idx           = free_idx_q;
                valid_d[free_idx_q] = 1'b1;
                count_d          = count_q + CNT_W'(1);
              end else begin
                res_d.full_res = 1'b1;
              end
            end
            CMD_GET: begin
              if (hit_q) begin
                res_d.value_out = hit_val_q;
              end
            end
            CMD_REMOVE: begin
              if (hit_q) begin
                valid_d[hit_idx_q] = 1'b0;
                count_d = count_q - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          res_d.entry_count = ENTRY_W'(count_d);
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_rd) begin
      key_rd_q <= key_mem[issue_q[IDX_W-1:0]];
      val_rd_q <= val_mem[issue_q[IDX_W-1:0]];
      rd_idx_q <= issue_q[IDX_W-1:0];
    end
    if (wr_key) begin
      key_mem[wr_idx] <= req_q.key;
    end
    if (wr_val) begin
      val_mem[wr_idx] <= req_q.val;
    end
    if (state_q == ST_IDLE && req_valid_i) begin
      req_q <= req_i;
    end
    hit_idx_q  <= hit_idx_d;
    hit_val_q  <= hit_val_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      count_q   <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      free_ok_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      hit_q     <= hit_d;
      free_ok_q <= free_ok_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule
`default_nettype wire

// File: src/code_point_map_table.sv
// Code point key-value table of CAPACITY entries. Each request (cmd in tuser:
// add/update, get, remove, clear) gives one response. A non-clear request scans
// every entry through the single read port of the key/value memory, one entry
// per cycle; a clear request skips the scan and goes straight to the finish state.
// A two-deep request queue keeps the input side open while a request is at work.
`default_nettype none
module code_point_map_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // key[20:0], mapped_value[41:21], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // found[0], value_out[21:1], full_res[22],
                                          // entry_count[29:23], zero pad
);
  import cpmt_pkg::*;

  logic q_valid, q_ready;
  req_t q_req;
  res_t res;

  cpmt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_key_i    (s_axis_tdata[20:0]),
    .in_val_i    (s_axis_tdata[41:21]),
    .req_valid_o (q_valid),
    .req_ready_i (q_ready),
    .req_o       (q_req)
  );

  cpmt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_ready_o (q_ready),
    .req_i       (q_req),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.entry_count, res.full_res, res.value_out, res.found};

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.full_res |-> !res.found) else $error("full with hit");
  a_value_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.value_out != '0 |-> res.found) else $error("value without hit");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (CAPACITY > 127) || (res.entry_count <= ENTRY_W'(CAPACITY)))
    else $error("count over capacity");

endmodule
`default_nettype wire

// File: test/code_point_map_table_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module code_point_map_table_tb;
  import cpmt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  code_point_map_table uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  logic [CP_W-1:0] tbl_key [CAPACITY];
  logic [CP_W-1:0] tbl_val [CAPACITY];
  logic            tbl_vld [CAPACITY];
  int              tbl_cnt;
  res_t            pending_res[$];
  int              errors = 0;
  int              rx_idle_pct = 28;
  int              tx_idle_pct = 28;
  bit              rx_hold = 1'b0;
  int              idle_cycles = 0;
  logic [CP_W-1:0] used_keys[$];

  function automatic res_t map_predict(cmd_e cmd, logic [CP_W-1:0] key,
                                       logic [CP_W-1:0] val);
    res_t r;
    int   slot;
    int   free;
    r = '0;
    slot = -1;
    free = -1;
    if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < CAPACITY; i++) tbl_vld[i] = 1'b0;
      tbl_cnt = 0;
    end else begin
      for (int i = CAPACITY - 1; i >= 0; i--) begin
        if (tbl_vld[i] && tbl_key[i] == key) slot = i;
        if (!tbl_vld[i]) free = i;
      end
      r.found = (slot >= 0);
      case (cmd)
        CMD_ADD: begin
          if (slot >= 0) begin
            tbl_val[slot] = val;
          end else if (free < 0) begin
            r.full_res = 1'b1;
          end else begin
            tbl_key[free] = key;
            tbl_val[free] = val;
            tbl_vld[free] = 1'b1;
            tbl_cnt++;
          end
        end
        CMD_GET: begin
          if (slot >= 0) r.value_out = tbl_val[slot];
        end
        default: begin
          if (slot >= 0) begin
            tbl_vld[slot] = 1'b0;
            if (tbl_cnt > 0) tbl_cnt--;
          end
        end
      endcase
    end
    r.entry_count = tbl_cnt[ENTRY_W-1:0];
    return r;
  endfunction

  task automatic send_request(cmd_e cmd, logic [CP_W-1:0] key, logic [CP_W-1:0] val);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'd0, val, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_res.push_back(map_predict(cmd, key, val));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [CP_W-1:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(99) < 75)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    return 21'($urandom());
  endfunction

  always @(posedge clk_i) begin
    if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found       = m_axis_tdata[0];
      got.value_out   = m_axis_tdata[21:1];
      got.full_res    = m_axis_tdata[22];
      got.entry_count = m_axis_tdata[29:23];
      if (pending_res.size() == 0) begin
        $display("%0t unexpected response actual %h", $time, got);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got.found !== want.found || got.value_out !== want.value_out ||
            got.full_res !== want.full_res || got.entry_count !== want.entry_count) begin
          $display("%0t mismatch expected found=%0d val=%h full=%0d cnt=%0d",
                   $time, want.found, want.value_out, want.full_res, want.entry_count,
                   " actual found=%0d val=%h full=%0d cnt=%0d",
                   got.found, got.value_out, got.full_res, got.entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("code_point_map_table_tb failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(CMD_GET, 21'd0, 21'd0);
    send_request(CMD_REMOVE, 21'h1FFFFF, 21'd0);
    send_request(CMD_ADD, 21'd0, 21'h1FFFFF);
    send_request(CMD_ADD, 21'h1FFFFF, 21'd0);
    send_request(CMD_ADD, 21'd1114111, 21'd1114111);
    send_request(CMD_GET, 21'd0, 21'd5);
    send_request(CMD_GET, 21'h1FFFFF, 21'd5);
    send_request(CMD_ADD, 21'd0, 21'h155555);
    send_request(CMD_GET, 21'd0, 21'd0);
    send_request(CMD_REMOVE, 21'd0, 21'd0);
    send_request(CMD_REMOVE, 21'd0, 21'd0);
    send_request(CMD_GET, 21'd0, 21'd0);
    send_request(CMD_CLEAR, 21'h0AAAAA, 21'h155555);
    send_request(CMD_GET, 21'h1FFFFF, 21'd0);
    drain_results();
  endtask

  task automatic test_capacity();
    for (int i = 0; i < CAPACITY; i++)
      send_request(CMD_ADD, 21'(i * 977 + 3), 21'(i));
    send_request(CMD_ADD, 21'h1FFFFE, 21'd7);
    send_request(CMD_ADD, 21'd3, 21'h1FFFFF);
    send_request(CMD_GET, 21'd3, 21'd0);
    send_request(CMD_REMOVE, 21'(5 * 977 + 3), 21'd0);
    send_request(CMD_ADD, 21'h1FFFFE, 21'd9);
    send_request(CMD_GET, 21'h1FFFFE, 21'd0);
    drain_results();
  endtask

  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (600) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_request(cmd_e'($urandom_range(2)), 21'($urandom_range(20)), 21'($urandom()));
    join
    drain_results();
  endtask

  task automatic test_random(int n, int rx_pct, int tx_pct);
    int   r;
    cmd_e cmd;
    logic [CP_W-1:0] k;
    rx_idle_pct = rx_pct;
    tx_idle_pct = tx_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      cmd = (r < 45) ? CMD_ADD : (r < 75) ? CMD_GET : (r < 97) ? CMD_REMOVE : CMD_CLEAR;
      k = pick_key();
      if (used_keys.size() < 90) used_keys.push_back(k);
      send_request(cmd, k, 21'($urandom()));
    end
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) tbl_vld[i] = 1'b0;
    tbl_cnt = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random(700, 28, 28);
    test_random(350, 0, 0);
    test_random(650, 28, 28);
    if (errors == 0) begin
      $display("code_point_map_table_tb passed");
    end else begin
      $display("code_point_map_table_tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
